[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files; only majority_over_third_select.sv includes them.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

[hw/rtl/mots_pkg.sv]
// Shared types and constants for the majority-over-third selector.
// No dependencies.
`default_nettype none

package mots_pkg;

  localparam int MAX_ITEMS = 4096;
  localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     found;
    logic                     status;
    logic                     last_result;
  } result_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic judge;
    logic next_res;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_addr;
    logic second_pend;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/mots_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module mots_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mots_ctrl.sv]
// Sequencer for load, buffer walk, judgement and result delivery.
// Depends on mots_pkg.
`default_nettype none

module mots_ctrl
  import mots_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  wire logic item_last,
  output      logic item_ready,
  output      logic result_valid,
  input  wire logic result_ready,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_WALK,
    S_FLUSH,
    S_JUDGE,
    S_EMIT
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;

  assign item_ready = (state == S_LOAD);

  always_comb begin
    state_next        = state;
    result_valid_next = result_valid;
    cmd               = '0;
    unique case (state)
      S_LOAD: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (item_last) begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.rd_issue = 1'b1;
        if (sts.last_addr) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        cmd.judge         = 1'b1;
        result_valid_next = 1'b1;
        state_next        = S_EMIT;
      end
      S_EMIT: begin
        if (result_ready) begin
          if (sts.second_pend) begin
            cmd.next_res = 1'b1;
          end else begin
            cmd.clear         = 1'b1;
            result_valid_next = 1'b0;
            state_next        = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mots_dp.sv]
// Datapath: vote registers, value buffer, exact counters, result register.
// Depends on mots_pkg and mots_ram.
`default_nettype none

module mots_dp
  import mots_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire item_t   item,
  input  wire cmd_t    cmd,
  output      sts_t    sts,
  output      result_t result
);

  logic [DATA_W-1:0] cand1, cand2;
  logic [CNT_W-1:0]  votes1, votes2;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  tc1, tc2;
  logic              rd_pend;
  logic              second_pend;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] v;
  logic              has_room;
  logic              wr_en;
  logic [CNT_W+1:0]  tc1_x3, tc2_x3;
  logic              ok1, ok2;

  assign v        = item.value;
  assign has_room = (count < CNT_W'(MAX_ITEMS));
  assign wr_en    = cmd.accept && has_room;

  mots_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (v),
    .rd_en   (cmd.rd_issue),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // count > floor(n/3) is the same test as 3*count > n
  assign tc1_x3 = {2'b00, tc1} + {1'b0, tc1, 1'b0};
  assign tc2_x3 = {2'b00, tc2} + {1'b0, tc2, 1'b0};
  assign ok1    = tc1_x3 > {2'b00, count};
  assign ok2    = tc2_x3 > {2'b00, count};

  assign sts.last_addr   = ({{(CNT_W-ADDR_W){1'b0}}, addr} == (count - CNT_W'(1)));
  assign sts.second_pend = second_pend;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cand1       <= '0;
      cand2       <= '0;
      votes1      <= '0;
      votes2      <= '0;
      count       <= '0;
      ovf         <= 1'b0;
      addr        <= '0;
      tc1         <= '0;
      tc2         <= '0;
      rd_pend     <= 1'b0;
      second_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
      if (cmd.accept) begin
        if (has_room) begin
          count <= count + CNT_W'(1);
          priority if (v == cand1) begin
            votes1 <= votes1 + CNT_W'(1);
          end else if (v == cand2) begin
            votes2 <= votes2 + CNT_W'(1);
          end else if (votes1 == '0) begin
            cand1  <= v;
            votes1 <= CNT_W'(1);
          end else if (votes2 == '0) begin
            cand2  <= v;
            votes2 <= CNT_W'(1);
          end else begin
            votes1 <= votes1 - CNT_W'(1);
            votes2 <= votes2 - CNT_W'(1);
          end
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.rd_issue) begin
        addr <= addr + ADDR_W'(1);
      end
      if (rd_pend) begin
        priority if (rd_data == cand1) begin
          tc1 <= tc1 + CNT_W'(1);
        end else if (rd_data == cand2) begin
          tc2 <= tc2 + CNT_W'(1);
        end
      end
      if (cmd.judge) begin
        second_pend <= ok1 && ok2;
      end
      if (cmd.next_res) begin
        second_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      result.status <= ovf;
      priority if (ok1) begin
        result.element     <= cand1;
        result.found       <= 1'b1;
        result.last_result <= !ok2;
      end else if (ok2) begin
        result.element     <= cand2;
        result.found       <= 1'b1;
        result.last_result <= 1'b1;
      end else begin
        result.element     <= '0;
        result.found       <= 1'b0;
        result.last_result <= 1'b1;
      end
    end else if (cmd.next_res) begin
      result.element     <= cand2;
      result.found       <= 1'b1;
      result.status      <= ovf;
      result.last_result <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/majority_over_third_select.sv]
// Majority-over-third selector. Requests on item carry one signed 32-bit
// value and a last flag; requests on result carry element, found, status
// and last_result. Both channels use valid/ready.
// While loading, one item request is accepted every cycle. The accepted
// values go into a 4096-entry buffer as a two-candidate vote runs on them;
// values past the buffer capacity are dropped and flagged in status.
// After the item marked last, item_ready drops; the buffer is walked once,
// one entry per cycle through the RAM read port, to count both candidates.
// The first result becomes valid after the WALK, FLUSH and JUDGE states
// that follow acceptance of the last item. One or two results follow, the
// final one marked with last_result; a set with no qualifying element
// gives one result with found clear. A stalled receiver holds the result
// register and the block accepts no item until the final result is taken;
// it then clears its vote state and takes the next set.
// Reset clears all control state; no clearing pass is needed.
// Depends on mots_pkg, mots_ctrl, mots_dp, mots_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module majority_over_third_select
  import mots_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output      logic    item_ready,
  input  wire item_t   item,
  output      logic    result_valid,
  input  wire logic    result_ready,
  output      result_t result
);

  cmd_t cmd;
  sts_t sts;

  mots_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_last    (item.last),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mots_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

  `ASSERT_NEVER(a_load_emit_excl, clk, rst, item_ready && result_valid)
  `ASSERT_PROP(a_notfound_final, clk, rst, (result_valid && !result.found) |-> result.last_result)
  `ASSERT_PROP(a_final_to_load, clk, rst, (result_valid && result_ready && result.last_result) |=> item_ready)
  `ASSERT_PROP(a_last_stops_load, clk, rst, (item_valid && item_ready && item.last) |=> !item_ready)

endmodule

`default_nettype wire

[sim/majority_over_third_select_tb.sv]
// Testbench for majority_over_third_select: directed sets, then random sets with
// one overflowing set, checked against an in-bench majority-over-third predictor.
// Depends on mots_pkg and the majority_over_third_select RTL.
`timescale 1ns / 1ps

module majority_over_third_select_tb;
  import mots_pkg::*;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;
  localparam int   CYCLE_LIMIT    = 1000000;
  localparam int   RANDOM_ITEMS   = 1950;
  localparam int   IDLE_PCT       = 18;
  localparam int   DIRECTED_LEN   = 25;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    result_t           exp;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
    '{32'h0000_0000, 1'b1, 1'b1, '{32'sh0000_0000, 1'b1, STATUS_OK, 1'b1}},
    '{32'h7fff_ffff, 1'b1, 1'b1, '{32'sh7fff_ffff, 1'b1, STATUS_OK, 1'b1}},
    '{32'h8000_0000, 1'b1, 1'b1, '{32'sh8000_0000, 1'b1, STATUS_OK, 1'b1}},
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0003, 1'b1, 1'b1, '{32'sh0000_0000, 1'b0, STATUS_OK, 1'b1}},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0007, 1'b0, 1'b0, '0},
    '{32'h0000_0007, 1'b0, 1'b0, '0},
    '{32'h0000_0009, 1'b1, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0006, 1'b1, 1'b0, '0},
    '{32'h0000_0008, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b1, 1'b0, '0},
    '{32'hffff_ffff, 1'b0, 1'b0, '0},
    '{32'hffff_ffff, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'hffff_ffff, 1'b1, 1'b0, '0},
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'haaaa_aaaa, 1'b1, 1'b0, '0}
  };

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int      cycle_count   = 0;
  int      mismatch_count = 0;
  bit      calm          = 1'b0;

  result_t           pending_results[$];
  logic [DATA_W-1:0] held_values[MAX_ITEMS];
  int                held_count = 0;
  logic [DATA_W-1:0] cand_a     = '0;
  logic [DATA_W-1:0] cand_b     = '0;
  int                votes_a    = 0;
  int                votes_b    = 0;
  logic              dropped    = 1'b0;

  majority_over_third_select i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic result_t make_result(input logic [DATA_W-1:0] elem, input logic hit,
                                          input logic final_one);
    result_t r;
    r.element     = elem;
    r.found       = hit;
    r.status      = dropped ? STATUS_DROPPED : STATUS_OK;
    r.last_result = final_one;
    return r;
  endfunction

  task automatic add_expected(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic predict_selection(input item_t it, input bit record);
    int unsigned third;
    int unsigned hits_a;
    int unsigned hits_b;
    logic [DATA_W-1:0] v;
    v = it.value;
    if (held_count < MAX_ITEMS) begin
      held_values[held_count] = v;
      held_count++;
      if (v == cand_a) votes_a++;
      else if (v == cand_b) votes_b++;
      else if (votes_a == 0) begin
        cand_a  = v;
        votes_a = 1;
      end else if (votes_b == 0) begin
        cand_b  = v;
        votes_b = 1;
      end else begin
        votes_a--;
        votes_b--;
      end
    end else begin
      dropped = 1'b1;
    end
    if (!it.last) return;
    hits_a = 0;
    hits_b = 0;
    for (int i = 0; i < held_count; i++) begin
      if (held_values[i] == cand_a) hits_a++;
      else if (held_values[i] == cand_b) hits_b++;
    end
    third = held_count / 3;
    if (record) begin
      if (hits_a > third) add_expected(make_result(cand_a, 1'b1, hits_b <= third));
      if (hits_b > third) add_expected(make_result(cand_b, 1'b1, 1'b1));
      if (hits_a <= third && hits_b <= third)
        add_expected(make_result('0, 1'b0, 1'b1));
    end
    cand_a     = '0;
    cand_b     = '0;
    votes_a    = 0;
    votes_b    = 0;
    held_count = 0;
    dropped    = 1'b0;
  endtask

  task automatic send_item(input logic [DATA_W-1:0] v, input logic fin, input bit record);
    item_t it;
    it.value = v;
    it.last  = fin;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    predict_selection(it, record);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_set(input int len, input bit noisy);
    logic [DATA_W-1:0] pool[4];
    int kinds;
    logic [DATA_W-1:0] v;
    kinds = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(7))
        0:       pool[k] = '0;
        1:       pool[k] = 32'h8000_0000;
        2:       pool[k] = 32'h7fff_ffff;
        default: pool[k] = $urandom;
      endcase
    end
    for (int j = 0; j < len; j++) begin
      if (noisy) v = $urandom;
      else if ($urandom_range(1) == 0) v = pool[0];
      else v = pool[$urandom_range(kinds - 1)];
      send_item(v, j == len - 1, 1'b1);
    end
  endtask

  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: element %0d found %0b status %0b last_result %0b",
                 result.element, result.found, result.status, result.last_result);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.element !== want.element) begin
            $error("element: expected %0d, got %0d", want.element, result.element);
            mismatch_count++;
          end
          if (result.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, result.found);
            mismatch_count++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, result.status);
            mismatch_count++;
          end
          if (result.last_result !== want.last_result) begin
            $error("last_result: expected %0b, got %0b", want.last_result, result.last_result);
            mismatch_count++;
          end
        end
      end
      result_ready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int random_sent;
    int len;
    int sets;
    bit overflow_sent;
    random_sent   = 0;
    sets          = 0;
    overflow_sent = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].typed) add_expected(DIRECTED[i].exp);
      send_item(DIRECTED[i].value, DIRECTED[i].last, !DIRECTED[i].typed);
    end
    drain_results();

    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent >= 700 && random_sent < 1100);
      // fill the buffer and drop four values, the last one among them
      if (!overflow_sent && random_sent >= 1100) begin
        overflow_sent = 1'b1;
        send_set(MAX_ITEMS + 4, 1'b0);
        random_sent += MAX_ITEMS + 4;
      end
      if (sets % 10 == 3) drain_results();
      case ($urandom_range(19))
        0:       len = $urandom_range(65, 300);
        1, 2, 3: len = $urandom_range(13, 64);
        default: len = $urandom_range(1, 12);
      endcase
      send_set(len, $urandom_range(9) == 0);
      random_sent += len;
      sets++;
    end
    calm = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[majority_over_third_select.f]
+incdir+hw/rtl
hw/rtl/mots_pkg.sv
hw/rtl/mots_ram.sv
hw/rtl/mots_ctrl.sv
hw/rtl/mots_dp.sv
hw/rtl/majority_over_third_select.sv
sim/majority_over_third_select_tb.sv
